// ===== src/sqvg_pkg.sv =====
`default_nettype none
package sqvg_pkg;
   localparam int InstanceLimit = 1024;
   localparam int IdxW = 10;
   localparam int CordicSteps = 14;
   localparam logic signed [17:0] CordicGain = 18'sd19898;
   localparam logic signed [23:0] DepthReset = 24'sd256;
   localparam logic signed [23:0] PosMax = 24'sh7FFFFF;
   localparam logic signed [23:0] PosMin = -24'sh800000;

   function automatic logic signed [15:0] atan_lut(input logic [3:0] i);
      logic signed [15:0] r;
      case (i)
         4'd0: r = 16'sd8192;
         4'd1: r = 16'sd4836;
         4'd2: r = 16'sd2555;
         4'd3: r = 16'sd1297;
         4'd4: r = 16'sd651;
         4'd5: r = 16'sd326;
         4'd6: r = 16'sd163;
         4'd7: r = 16'sd81;
         4'd8: r = 16'sd41;
         4'd9: r = 16'sd20;
         4'd10: r = 16'sd10;
         4'd11: r = 16'sd5;
         4'd12: r = 16'sd3;
         4'd13: r = 16'sd1;
         default: r = 16'sd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== src/sqvg_cordic.sv =====
`default_nettype none
module sqvg_cordic (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [15:0] angle,
   output logic done,
   output logic signed [17:0] sin_out,
   output logic signed [17:0] cos_out
);
   import sqvg_pkg::*;
   logic signed [17:0] x_ff, x_in, y_ff, y_in;
   logic signed [16:0] z_ff, z_in;
   logic [3:0] step_ff, step_in;
   logic busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic signed [16:0] az;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; step_in = step_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      az = 17'(angle);
      if (start) begin
         x_in = CordicGain; y_in = '0; step_in = '0; busy_in = 1'b1; neg_in = 1'b0;
         z_in = az;
         if (az > 17'sd16384) begin
            z_in = az - 17'sd32768; neg_in = 1'b1;
         end else if (az < -17'sd16384) begin
            z_in = az + 17'sd32768; neg_in = 1'b1;
         end
      end else if (busy_ff) begin
         // one rotation a cycle through the shared add/shift unit
         if (z_ff >= 0) begin
            x_in = x_ff - (y_ff >>> step_ff);
            y_in = y_ff + (x_ff >>> step_ff);
            z_in = z_ff - 17'(atan_lut(step_ff));
         end else begin
            x_in = x_ff + (y_ff >>> step_ff);
            y_in = y_ff - (x_ff >>> step_ff);
            z_in = z_ff + 17'(atan_lut(step_ff));
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(CordicSteps - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; step_ff <= step_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

`ifndef NO_ASSERTIONS
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy_ff) else $error("done while busy");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("start while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done not a pulse");
`endif
endmodule
`default_nettype wire

// ===== src/sprite_quad_vertex_generator.sv =====
`default_nettype none
// Rotated sprite quad to two triangles. A sprite transfer is taken only when
// the block is idle, so the next sprite waits until the sixth vertex has left.
// A 14-step CORDIC (one step a cycle) finds sine and cosine; rotation starts
// once the CORDIC signals done. Each of the six vertices (corners 0,3,1,1,3,2)
// then passes through one pair of 25x18 multipliers: x product, y product
// with x rounding and saturation, y rounding and saturation, and the output
// transfer, which waits out any output stall. After the last vertex transfers
// the block returns to idle and the next sprite can transfer in the next cycle.
// Positions saturate to Q15.8; depth comes from the csr register (reset 1.0);
// instance_index restarts on first_of_batch and holds at the instance limit
// minus one.
module sprite_quad_vertex_generator (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic req_first_of_batch,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic [22:0] req_size_w,
   input  wire logic [22:0] req_size_h,
   input  wire logic signed [23:0] req_pivot_x,
   input  wire logic signed [23:0] req_pivot_y,
   input  wire logic signed [15:0] req_angle,
   input  wire logic [31:0] req_uv_top_left,
   input  wire logic [31:0] req_uv_bottom_right,
   input  wire logic [31:0] req_packed_color,
   input  wire logic [15:0] req_texture_id,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [23:0] rsp_vert_x,
   output logic signed [23:0] rsp_vert_y,
   output logic signed [23:0] rsp_vert_z,
   output logic [15:0] rsp_tex_u,
   output logic [15:0] rsp_tex_v,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_alpha,
   output logic [9:0] rsp_instance_index,
   output logic [15:0] rsp_slot_out,
   output logic rsp_last_vertex,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic signed [23:0] csr_depth_value
);
   import sqvg_pkg::*;

   localparam logic [2:0] StIdle = 3'd0, StTrig = 3'd1, StRotX = 3'd2,
      StRotY = 3'd3, StOut = 3'd4;

   logic [2:0] state_ff, state_in;
   logic signed [23:0] depth_ff;
   logic [IdxW-1:0] count_ff, count_in, idx_ff, idx_in;
   logic signed [24:0] tx_ff, ty_ff;
   logic signed [24:0] pvx_ff, pvy_ff;
   logic [22:0] w_ff, h_ff;
   logic [31:0] uvtl_ff, uvbr_ff, col_ff;
   logic [15:0] slot_ff;
   logic signed [17:0] sn_ff, cs_ff;
   logic [2:0] vtx_ff, vtx_in;
   logic signed [42:0] acc_ff, acc_in;
   logic signed [23:0] vx_ff, vx_in, vy_ff, vy_in;
   logic ov_ff, ov_in;
   logic cordic_start, cordic_done;
   logic signed [17:0] sn_w, cs_w;
   logic [1:0] corner;
   logic signed [24:0] cxv, cyv, opa, opb;
   logic signed [17:0] ma, mb;
   logic signed [42:0] prod_a, prod_b, sum;
   logic signed [27:0] rnd;
   logic signed [28:0] fin;
   logic signed [23:0] sat;
   logic right, bottom;
   logic [IdxW:0] next_cnt;

   // the angle is taken by the CORDIC on the same edge as the sprite transfer
   sqvg_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cordic_start), .angle(req_angle),
      .done(cordic_done), .sin_out(sn_w), .cos_out(cs_w));

   always_comb begin
      case (vtx_ff)
         3'd0: corner = 2'd0;
         3'd1: corner = 2'd3;
         3'd2: corner = 2'd1;
         3'd3: corner = 2'd1;
         3'd4: corner = 2'd3;
         3'd5: corner = 2'd2;
         default: corner = 2'd0;
      endcase
   end

   assign right  = (corner == 2'd1) || (corner == 2'd2);
   assign bottom = (corner == 2'd2) || (corner == 2'd3);
   assign cxv = right  ? 25'($signed({2'b00, w_ff})) - pvx_ff : -pvx_ff;
   assign cyv = bottom ? 25'($signed({2'b00, h_ff})) - pvy_ff : -pvy_ff;

   // x pass: c*cx - s*cy ; y pass: s*cx + c*cy
   assign ma = (state_ff == StRotX) ? cs_ff : sn_ff;
   assign mb = (state_ff == StRotX) ? sn_ff : cs_ff;
   assign opa = cxv;
   assign opb = cyv;
   assign prod_a = 43'(ma * opa);
   assign prod_b = 43'(mb * opb);
   assign sum = (state_ff == StRotX) ? prod_a - prod_b : prod_a + prod_b;

   assign rnd = 28'((acc_ff + 43'sd16384) >>> 15);
   assign fin = 29'(rnd) + 29'((state_ff == StRotY) ? tx_ff : ty_ff);
   assign sat = (fin > 29'(PosMax)) ? PosMax :
                (fin < 29'(PosMin)) ? PosMin : fin[23:0];

   assign cordic_start = (state_ff == StIdle) && req_valid;
   assign next_cnt = {1'b0, idx_in} + 1'b1;

   always_comb begin
      state_in = state_ff; vtx_in = vtx_ff; acc_in = acc_ff;
      vx_in = vx_ff; vy_in = vy_ff; ov_in = ov_ff; count_in = count_ff; idx_in = idx_ff;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               idx_in = req_first_of_batch ? '0 : count_ff;
               count_in = (next_cnt > (IdxW+1)'(InstanceLimit - 1)) ?
                  IdxW'(InstanceLimit - 1) : next_cnt[IdxW-1:0];
               vtx_in = '0;
               state_in = StTrig;
            end
         end
         StTrig: if (cordic_done) state_in = StRotX;
         StRotX: begin
            acc_in = sum;
            state_in = StRotY;
         end
         StRotY: begin
            vx_in = sat;   // finish x, start y product
            acc_in = sum;
            state_in = StOut;
            ov_in = 1'b0;
         end
         StOut: begin
            // finish y in first cycle of this state, then hold for transfer
            if (!ov_ff) begin
               vy_in = sat; ov_in = 1'b1;
            end else if (!rsp_stall) begin
               ov_in = 1'b0;
               if (vtx_ff == 3'd5) state_in = StIdle;
               else begin
                  vtx_in = vtx_ff + 3'd1; state_in = StRotX;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; vx_ff <= vx_in; vy_ff <= vy_in; idx_ff <= idx_in;
      if (cordic_done) begin
         sn_ff <= sn_w; cs_ff <= cs_w;
      end
      if (cordic_start) begin
         tx_ff <= 25'(req_pos_x) + 25'(req_pivot_x);
         ty_ff <= 25'(req_pos_y) + 25'(req_pivot_y);
         pvx_ff <= 25'(req_pivot_x); pvy_ff <= 25'(req_pivot_y);
         w_ff <= req_size_w; h_ff <= req_size_h;
         uvtl_ff <= req_uv_top_left; uvbr_ff <= req_uv_bottom_right;
         col_ff <= req_packed_color; slot_ff <= req_texture_id;
      end
      if (reset) begin
         state_ff <= StIdle; vtx_ff <= '0; ov_ff <= 1'b0; count_ff <= '0;
         depth_ff <= DepthReset;
      end else begin
         state_ff <= state_in; vtx_ff <= vtx_in; ov_ff <= ov_in; count_ff <= count_in;
         if (csr_valid && csr_ready) depth_ff <= csr_depth_value;
      end
   end

   assign req_stall = (state_ff != StIdle);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == StOut) && ov_ff;
   assign rsp_vert_x = vx_ff;
   assign rsp_vert_y = vy_ff;
   assign rsp_vert_z = depth_ff;
   assign rsp_tex_u = right ? uvbr_ff[31:16] : uvtl_ff[31:16];
   assign rsp_tex_v = bottom ? uvbr_ff[15:0] : uvtl_ff[15:0];
   assign rsp_red = col_ff[31:24];
   assign rsp_green = col_ff[23:16];
   assign rsp_blue = col_ff[15:8];
   assign rsp_alpha = col_ff[7:0];
   assign rsp_instance_index = idx_ff;
   assign rsp_slot_out = slot_ff;
   assign rsp_last_vertex = (vtx_ff == 3'd5);

`ifndef NO_ASSERTIONS
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StIdle) |-> !rsp_valid) else $error("response while idle");
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IdxW'(InstanceLimit - 1)) else $error("counter overflow");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_vertex) |=> (state_ff == StIdle))
      else $error("no idle after last vertex");
`endif
endmodule
`default_nettype wire
